### sv/asls_pkg.sv
package asls_pkg;

  localparam int CODE_BITS_DEF = 6;
  localparam int MAX_INDEX_MODULATOR = 8;
  localparam int MAX_INDEX_TEN_CHANNEL = 9;

  localparam int BOARD_W = 3;
  localparam int INDEX_W = 4;
  localparam int CODE_W = 6;
  localparam int REG_W = 3;
  localparam int BYTE_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int STEP_W = 4;
  localparam int LATCH_SPLIT = 6;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_ARMED   = 2'd2
  } status_t;

  typedef enum logic [BOARD_W-1:0] {
    BOARD_NONE      = 3'd0,
    BOARD_MODULATOR = 3'd1,
    BOARD_DIRECT    = 3'd2,
    BOARD_TEN       = 3'd3
  } board_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLOCK_MASK  = 2'd0,
    CFG_DATA_MASK   = 2'd1,
    CFG_SELECT_MASK = 2'd2
  } cfg_index_t;

  localparam logic [REG_W-1:0] EXP_OUTPUT_REG0 = 3'd2;
  localparam logic [REG_W-1:0] EXP_OUTPUT_REG1 = 3'd3;
  localparam logic [REG_W-1:0] EXP_CONFIG_REG0 = 3'd6;
  localparam logic [REG_W-1:0] EXP_CONFIG_REG1 = 3'd7;

  // register selection of one microcode step
  typedef enum logic [2:0] {
    RS_NONE,
    RS_CONFIG0,
    RS_CONFIG1,
    RS_OUTPUT0,
    RS_OUTPUT1,
    RS_LATCH
  } reg_sel_t;

  // value selection of one microcode step
  typedef enum logic [2:0] {
    VS_ZERO,
    VS_SELECT,
    VS_BIT,
    VS_BIT_CLOCK,
    VS_LATCH,
    VS_RELEASE
  } val_sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_SKIP_SELECT,
    JMP_BITS_LEFT,
    JMP_END
  } jump_t;

  typedef struct packed {
    reg_sel_t rsel;
    val_sel_t vsel;
    logic     last;
    logic     shift;
    jump_t    jmp;
    step_t    target;
  } ctrl_word_t;

  localparam step_t STEP_ERROR   = 4'd0;
  localparam step_t STEP_DIR0    = 4'd1;
  localparam step_t STEP_DIR1    = 4'd2;
  localparam step_t STEP_CLEAR   = 4'd3;
  localparam step_t STEP_SELECT  = 4'd4;
  localparam step_t STEP_BIT_LO  = 4'd5;
  localparam step_t STEP_BIT_CLK = 4'd6;
  localparam step_t STEP_BIT_END = 4'd7;
  localparam step_t STEP_IDLE_LO = 4'd8;
  localparam step_t STEP_LATCH   = 4'd9;
  localparam step_t STEP_RELEASE = 4'd10;

  function automatic ctrl_word_t ucode(step_t step);
    ctrl_word_t w;
    w = '{RS_NONE, VS_ZERO, 1'b1, 1'b0, JMP_END, STEP_ERROR};
    unique case (step)
      STEP_ERROR:   w = '{RS_NONE,    VS_ZERO,      1'b1, 1'b0, JMP_END,  STEP_ERROR};
      STEP_DIR0:    w = '{RS_CONFIG0, VS_ZERO,      1'b0, 1'b0, JMP_NEXT, STEP_ERROR};
      STEP_DIR1:    w = '{RS_CONFIG1, VS_ZERO,      1'b0, 1'b0, JMP_NEXT, STEP_ERROR};
      STEP_CLEAR:   w = '{RS_OUTPUT0, VS_ZERO,      1'b0, 1'b0, JMP_SKIP_SELECT,
                          STEP_BIT_LO};
      STEP_SELECT:  w = '{RS_OUTPUT1, VS_SELECT,    1'b0, 1'b0, JMP_NEXT, STEP_ERROR};
      STEP_BIT_LO:  w = '{RS_OUTPUT0, VS_BIT,       1'b0, 1'b0, JMP_NEXT, STEP_ERROR};
      STEP_BIT_CLK: w = '{RS_OUTPUT0, VS_BIT_CLOCK, 1'b0, 1'b0, JMP_NEXT, STEP_ERROR};
      STEP_BIT_END: w = '{RS_OUTPUT0, VS_BIT,       1'b0, 1'b1, JMP_BITS_LEFT,
                          STEP_BIT_LO};
      STEP_IDLE_LO: w = '{RS_OUTPUT0, VS_ZERO,      1'b0, 1'b0, JMP_NEXT, STEP_ERROR};
      STEP_LATCH:   w = '{RS_LATCH,   VS_LATCH,     1'b0, 1'b0, JMP_NEXT, STEP_ERROR};
      STEP_RELEASE: w = '{RS_LATCH,   VS_RELEASE,   1'b1, 1'b0, JMP_END,  STEP_ERROR};
      default:      w = '{RS_NONE,    VS_ZERO,      1'b1, 1'b0, JMP_END,  STEP_ERROR};
    endcase
    return w;
  endfunction

endpackage

### sv/attenuator_serial_load_sequencer.sv
// the request registers and pc load when a request is taken, and the first word is
// registered at the first output advance after that; 3*CODE_BITS+6 words per request (one
// more on the vector-modulator board, 25 at most for the default CODE_BITS), or one word
// for a refused request; the microcode program issues one word per cycle, stalled by
// m_tready, and the next request can be taken in the cycle after the last word is registered
// reset (rst, synchronous): engine idle, output empty, pin masks back to defaults
module attenuator_serial_load_sequencer
  import asls_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // board_type[2:0], attenuator_index[6:3], attenuation_code[12:7], device_armed[13]
  input  logic [15:0]            s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status[1:0], expander_register[4:2], expander_value[12:5]
  output logic [15:0]            m_tdata,
  // write_valid[0]
  output logic                   m_tuser,
  output logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data
);

  localparam int CNT_W = $clog2(CODE_BITS + 1);

  logic [BYTE_W-1:0] clock_pin_mask;
  logic [BYTE_W-1:0] data_pin_mask;
  logic [BYTE_W-1:0] chip_select_mask;

  logic                 busy;
  step_t                pc;
  logic [BOARD_W-1:0]   board;
  status_t              status;
  logic [CODE_BITS-1:0] code_sr;
  logic [CNT_W-1:0]     bits_left;
  logic [REG_W-1:0]     latch_reg;
  logic [BYTE_W-1:0]    latch_val;
  logic [BYTE_W-1:0]    release_val;

  logic [BOARD_W-1:0] in_board;
  logic [INDEX_W-1:0] in_index;
  logic [CODE_W-1:0]  in_code;
  logic               in_armed;
  logic               accept;
  logic               advance;
  status_t            in_status;
  logic [CODE_BITS+CODE_W-1:0] code_ext;
  logic [15:0]        latch_shift;
  logic               in_modulator;

  ctrl_word_t         cw;
  logic [BYTE_W-1:0]  clk_mask;
  logic [BYTE_W-1:0]  dat_mask;
  logic [BYTE_W-1:0]  bit_val;
  logic [REG_W-1:0]   out_reg;
  logic [BYTE_W-1:0]  out_val;
  step_t              pc_next;
  logic               done;

  assign in_board = s_tdata[2:0];
  assign in_index = s_tdata[6:3];
  assign in_code  = s_tdata[12:7];
  assign in_armed = s_tdata[13];

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign advance  = busy && (!m_tvalid || m_tready);

  assign in_modulator = (in_board == BOARD_MODULATOR);
  assign code_ext     = {{CODE_BITS{1'b0}}, in_code};

  always_comb begin
    in_status = ST_OK;
    if (in_armed) begin
      in_status = ST_ARMED;
    end else if (in_board == BOARD_MODULATOR || in_board == BOARD_DIRECT) begin
      if (in_index > INDEX_W'(MAX_INDEX_MODULATOR)) in_status = ST_INVALID;
    end else if (in_board == BOARD_TEN) begin
      if (in_index > INDEX_W'(MAX_INDEX_TEN_CHANNEL)) in_status = ST_INVALID;
    end else begin
      in_status = ST_INVALID;
    end
  end

  // latch bits past the byte drop out
  always_comb begin
    if (in_index < INDEX_W'(LATCH_SPLIT)) begin
      latch_shift = 16'(1) << (in_index + INDEX_W'(2));
    end else begin
      latch_shift = 16'(1) << (in_index - INDEX_W'(LATCH_SPLIT));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_pin_mask   <= 8'h01;
      data_pin_mask    <= 8'h02;
      chip_select_mask <= 8'h80;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOCK_MASK:  clock_pin_mask   <= cfg_data;
        CFG_DATA_MASK:   data_pin_mask    <= cfg_data;
        CFG_SELECT_MASK: chip_select_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    if (accept) begin
      board     <= in_board;
      status    <= in_status;
      code_sr   <= code_ext[CODE_BITS-1:0];
      bits_left <= CNT_W'(CODE_BITS - 1);
      if (in_index < INDEX_W'(LATCH_SPLIT)) begin
        latch_reg   <= EXP_OUTPUT_REG0;
        latch_val   <= latch_shift[BYTE_W-1:0];
        release_val <= '0;
      end else begin
        latch_reg <= EXP_OUTPUT_REG1;
        if (in_modulator) begin
          latch_val   <= latch_shift[BYTE_W-1:0] | chip_select_mask;
          release_val <= chip_select_mask;
        end else begin
          latch_val   <= latch_shift[BYTE_W-1:0];
          release_val <= '0;
        end
      end
    end else if (advance && cw.shift && bits_left != '0) begin
      code_sr   <= code_sr << 1;
      bits_left <= bits_left - CNT_W'(1);
    end
  end

  assign cw = ucode(pc);

  // direct-sampling board swaps clock and data pins
  always_comb begin
    if (board == BOARD_DIRECT) begin
      clk_mask = data_pin_mask;
      dat_mask = clock_pin_mask;
    end else begin
      clk_mask = clock_pin_mask;
      dat_mask = data_pin_mask;
    end
  end

  assign bit_val = code_sr[CODE_BITS-1] ? dat_mask : '0;

  always_comb begin
    unique case (cw.rsel)
      RS_NONE:    out_reg = '0;
      RS_CONFIG0: out_reg = EXP_CONFIG_REG0;
      RS_CONFIG1: out_reg = EXP_CONFIG_REG1;
      RS_OUTPUT0: out_reg = EXP_OUTPUT_REG0;
      RS_OUTPUT1: out_reg = EXP_OUTPUT_REG1;
      RS_LATCH:   out_reg = latch_reg;
      default:    out_reg = '0;
    endcase
  end

  always_comb begin
    unique case (cw.vsel)
      VS_ZERO:      out_val = '0;
      VS_SELECT:    out_val = chip_select_mask;
      VS_BIT:       out_val = bit_val;
      VS_BIT_CLOCK: out_val = bit_val | clk_mask;
      VS_LATCH:     out_val = latch_val;
      VS_RELEASE:   out_val = release_val;
      default:      out_val = '0;
    endcase
  end

  // sequencer jumps
  always_comb begin
    pc_next = pc + step_t'(1);
    done    = 1'b0;
    unique case (cw.jmp)
      JMP_NEXT:        pc_next = pc + step_t'(1);
      JMP_SKIP_SELECT: if (board != BOARD_MODULATOR) pc_next = cw.target;
      JMP_BITS_LEFT:   if (bits_left != '0) pc_next = cw.target;
      JMP_END:         done = 1'b1;
      default:         done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pc       <= STEP_ERROR;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !advance) m_tvalid <= 1'b0;
      if (accept) begin
        busy <= 1'b1;
        pc   <= (in_status == ST_OK) ? STEP_DIR0 : STEP_ERROR;
      end else if (advance) begin
        m_tvalid <= 1'b1;
        pc       <= pc_next;
        if (done) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {3'b000, out_val, out_reg, status};
      m_tuser <= (cw.rsel != RS_NONE);
      m_tlast <= cw.last;
    end
  end

endmodule

### verif/tb.sv
module tb;
  import asls_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int BOARD_BITS = BOARD_W;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [15:0]            m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]      cfg_data = '0;

  int stall_pct = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  typedef struct {
    status_t          status;
    logic             write_valid;
    logic [REG_W-1:0] exp_reg;
    logic [7:0]       value;
    logic             lst;
  } expander_write_t;

  class load_scoreboard;
    logic [7:0] clock_mask;
    logic [7:0] data_mask;
    logic [7:0] select_mask;
    expander_write_t expected_writes[$];
    int mismatches;

    function new();
      clock_mask = 8'h01;
      data_mask = 8'h02;
      select_mask = 8'h80;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_CLOCK_MASK: clock_mask = val;
        CFG_DATA_MASK: data_mask = val;
        CFG_SELECT_MASK: select_mask = val;
        default: ;
      endcase
    endfunction

    function void push_write(status_t st, logic wv, logic [REG_W-1:0] r, logic [7:0] v);
      expander_write_t w;
      w.status = st;
      w.write_valid = wv;
      w.exp_reg = r;
      w.value = v;
      w.lst = 1'b0;
      expected_writes.push_back(w);
    endfunction

    // expand one accepted request into its run of expander writes
    function void note_request(logic [15:0] word);
      logic [BOARD_W-1:0] board;
      logic [INDEX_W-1:0] idx;
      logic [CODE_W-1:0]  code;
      logic               armed;
      logic               fits;
      logic [7:0]         clk_bits;
      logic [7:0]         dat_bits;
      logic [7:0]         bit_val;
      logic [REG_W-1:0]   latch_reg;
      logic [7:0]         latch_val;
      logic [7:0]         release_val;
      board = word[2:0];
      idx = word[6:3];
      code = word[12:7];
      armed = word[13];
      case (board)
        BOARD_MODULATOR, BOARD_DIRECT: fits = (idx <= MAX_INDEX_MODULATOR);
        BOARD_TEN: fits = (idx <= MAX_INDEX_TEN_CHANNEL);
        default: fits = 1'b0;
      endcase
      if (armed || !fits) begin
        push_write(armed ? ST_ARMED : ST_INVALID, 1'b0, '0, '0);
      end else begin
        // direct-sampling board has clock and data pins swapped
        clk_bits = (board == BOARD_DIRECT) ? data_mask : clock_mask;
        dat_bits = (board == BOARD_DIRECT) ? clock_mask : data_mask;
        push_write(ST_OK, 1'b1, EXP_CONFIG_REG0, 8'h00);
        push_write(ST_OK, 1'b1, EXP_CONFIG_REG1, 8'h00);
        push_write(ST_OK, 1'b1, EXP_OUTPUT_REG0, 8'h00);
        if (board == BOARD_MODULATOR)
          push_write(ST_OK, 1'b1, EXP_OUTPUT_REG1, select_mask);
        for (int i = CODE_BITS_DEF - 1; i >= 0; i--) begin
          bit_val = code[i] ? dat_bits : 8'h00;
          push_write(ST_OK, 1'b1, EXP_OUTPUT_REG0, bit_val);
          push_write(ST_OK, 1'b1, EXP_OUTPUT_REG0, bit_val | clk_bits);
          push_write(ST_OK, 1'b1, EXP_OUTPUT_REG0, bit_val);
        end
        push_write(ST_OK, 1'b1, EXP_OUTPUT_REG0, 8'h00);
        if (idx < LATCH_SPLIT) begin
          latch_reg = EXP_OUTPUT_REG0;
          latch_val = 8'h01 << (idx + 2);
          release_val = 8'h00;
        end else begin
          latch_reg = EXP_OUTPUT_REG1;
          latch_val = 8'h01 << (idx - LATCH_SPLIT);
          release_val = 8'h00;
          if (board == BOARD_MODULATOR) begin
            latch_val = latch_val | select_mask;
            release_val = select_mask;
          end
        end
        push_write(ST_OK, 1'b1, latch_reg, latch_val);
        push_write(ST_OK, 1'b1, latch_reg, release_val);
      end
      expected_writes[expected_writes.size() - 1].lst = 1'b1;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_word(logic [15:0] data, logic wv, logic lst);
      expander_write_t e;
      if (expected_writes.size() == 0) begin
        report($sformatf("unexpected word data=%h user=%b last=%b", data, wv, lst));
        return;
      end
      e = expected_writes.pop_front();
      if (data[1:0] !== e.status)
        report($sformatf("status expected %0d got %0d", e.status, data[1:0]));
      if (wv !== e.write_valid)
        report($sformatf("write_valid expected %b got %b", e.write_valid, wv));
      if (data[4:2] !== e.exp_reg)
        report($sformatf("register expected %0d got %0d", e.exp_reg, data[4:2]));
      if (data[12:5] !== e.value)
        report($sformatf("value expected %h got %h", e.value, data[12:5]));
      if (lst !== e.lst)
        report($sformatf("last expected %b got %b", e.lst, lst));
    endfunction
  endclass

  load_scoreboard sb = new();

  attenuator_serial_load_sequencer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_request(s_tdata);
    if (!rst && m_tvalid && m_tready)
      sb.check_word(m_tdata, m_tuser, m_tlast);
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] pack_request(logic [2:0] board, logic [3:0] idx,
                                               logic [5:0] code, logic armed);
    return {2'b00, armed, code, idx, board};
  endfunction

  // mostly well-formed requests, the rest anything the fields allow
  function automatic logic [15:0] random_request();
    logic [BOARD_W-1:0] board;
    logic [INDEX_W-1:0] idx;
    logic               armed;
    if ($urandom_range(99) < 80) begin
      board = BOARD_BITS'($urandom_range(BOARD_MODULATOR, BOARD_TEN));
      idx = (board == BOARD_TEN) ? INDEX_W'($urandom_range(MAX_INDEX_TEN_CHANNEL))
                                 : INDEX_W'($urandom_range(MAX_INDEX_MODULATOR));
      armed = 1'b0;
    end else begin
      board = BOARD_BITS'($urandom_range(7));
      idx = INDEX_W'($urandom_range(15));
      armed = ($urandom_range(99) < 30);
    end
    return pack_request(board, idx, CODE_W'($urandom_range(63)), armed);
  endfunction

  task automatic send_request(logic [15:0] word, int idle_pct);
    s_tdata <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic run_random(int count, int idle_pct, bit pressure);
    for (int n = 0; n < count; n++) begin
      if (pressure && n == count / 2) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      // keep offering back to back while the receiver is held off
      if (pressure && n >= count / 2 && n < count / 2 + 6)
        send_request(random_request(), 0);
      else
        send_request(random_request(), idle_pct);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_register(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] directed[$];
    directed.push_back(pack_request(BOARD_MODULATOR, 4'd0, 6'd63, 1'b1));
    directed.push_back(pack_request(3'd7, 4'd15, 6'd0, 1'b1));
    directed.push_back(pack_request(BOARD_NONE, 4'd0, 6'd21, 1'b0));
    directed.push_back(pack_request(3'd4, 4'd2, 6'd42, 1'b0));
    directed.push_back(pack_request(3'd7, 4'd15, 6'd63, 1'b0));
    directed.push_back(pack_request(BOARD_MODULATOR, 4'd8, 6'd63, 1'b0));
    directed.push_back(pack_request(BOARD_MODULATOR, 4'd9, 6'd5, 1'b0));
    directed.push_back(pack_request(BOARD_MODULATOR, 4'd0, 6'd0, 1'b0));
    directed.push_back(pack_request(BOARD_MODULATOR, 4'd5, 6'd42, 1'b0));
    directed.push_back(pack_request(BOARD_MODULATOR, 4'd6, 6'd21, 1'b0));
    directed.push_back(pack_request(BOARD_DIRECT, 4'd8, 6'd42, 1'b0));
    directed.push_back(pack_request(BOARD_DIRECT, 4'd9, 6'd1, 1'b0));
    directed.push_back(pack_request(BOARD_DIRECT, 4'd0, 6'd63, 1'b0));
    directed.push_back(pack_request(BOARD_DIRECT, 4'd6, 6'd0, 1'b0));
    directed.push_back(pack_request(BOARD_TEN, 4'd9, 6'd32, 1'b0));
    directed.push_back(pack_request(BOARD_TEN, 4'd10, 6'd63, 1'b0));
    directed.push_back(pack_request(BOARD_TEN, 4'd15, 6'd1, 1'b0));
    directed.push_back(pack_request(BOARD_TEN, 4'd5, 6'd21, 1'b0));
    directed.push_back(pack_request(BOARD_TEN, 4'd7, 6'd63, 1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pin masks, no idling
    stall_pct = 0;
    foreach (directed[i]) send_request(directed[i], 0);
    run_random(30, 0, 0);
    settle();

    write_config(CFG_CLOCK_MASK, 8'hFF);
    write_config(CFG_DATA_MASK, 8'h00);
    write_config(CFG_SELECT_MASK, 8'h00);
    write_config(CFG_SPARE, 8'h5A);
    stall_pct = 0;
    foreach (directed[i]) if (i >= 5 && i < 14) send_request(directed[i], 76);
    run_random(30, 76, 0);
    settle();

    write_config(CFG_CLOCK_MASK, 8'h00);
    write_config(CFG_DATA_MASK, 8'hFF);
    write_config(CFG_SELECT_MASK, 8'hFF);
    stall_pct = 76;
    run_random(35, 0, 1);
    settle();

    write_config(CFG_CLOCK_MASK, 8'($urandom_range(255)));
    write_config(CFG_DATA_MASK, 8'($urandom_range(255)));
    write_config(CFG_SELECT_MASK, 8'($urandom_range(255)));
    write_config(CFG_SPARE, 8'($urandom_range(255)));
    stall_pct = 23;
    run_random(40, 23, 0);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_writes.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
